FILE: hdl/i2c_eeprom_byte_access_master_defines.svh
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: assertion macros
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CEE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("i2cee: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("i2cee: next-cycle check failed");

`endif

FILE: hdl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: package
// Item types, register indexes, commands and bus phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

	localparam int RECOVERY_COUNT_WIDTH = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_SELECT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_WAIT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_RECOVERY = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_READ_RECOVERY = 3'd4;

	localparam logic [6:0] DEVICE_SELECT_RESET = 7'd80;
	localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;
	localparam logic [7:0] ACK_WAIT_RESET = 8'd255;
	localparam logic [RECOVERY_COUNT_WIDTH-1:0] WRITE_RECOVERY_RESET =
		RECOVERY_COUNT_WIDTH'(1000000);
	localparam logic [RECOVERY_COUNT_WIDTH-1:0] READ_RECOVERY_RESET =
		RECOVERY_COUNT_WIDTH'(10000);

	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	typedef enum logic [16:0] {
		PH_IDLE = 17'h00001,
		PH_ST0  = 17'h00002,
		PH_ST1  = 17'h00004,
		PH_ST2  = 17'h00008,
		PH_ST3  = 17'h00010,
		PH_WLO  = 17'h00020,
		PH_WHI  = 17'h00040,
		PH_WREL = 17'h00080,
		PH_ACK  = 17'h00100,
		PH_RLO  = 17'h00200,
		PH_RHI  = 17'h00400,
		PH_NLO  = 17'h00800,
		PH_NHI  = 17'h01000,
		PH_P0   = 17'h02000,
		PH_P1   = 17'h04000,
		PH_P2   = 17'h08000,
		PH_REC  = 17'h10000
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] word_address;
		logic [7:0] write_data;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_missing;
	} out_item_t;

	typedef struct packed {
		logic [6:0]                      device_select;
		logic [7:0]                      half_period_ticks;
		logic [7:0]                      ack_wait_limit;
		logic [RECOVERY_COUNT_WIDTH-1:0] write_recovery_ticks;
		logic [RECOVERY_COUNT_WIDTH-1:0] read_recovery_ticks;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hdl/i2cee_cfg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: configuration registers
// Holds the bus address, timing and recovery settings written over the
// configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [i2cee_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]    wr_data,
	output i2cee_pkg::cfg_t                          cfg
);

	i2cee_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_select <= i2cee_pkg::DEVICE_SELECT_RESET;
			cfg_q.half_period_ticks <= i2cee_pkg::HALF_PERIOD_RESET;
			cfg_q.ack_wait_limit <= i2cee_pkg::ACK_WAIT_RESET;
			cfg_q.write_recovery_ticks <= i2cee_pkg::WRITE_RECOVERY_RESET;
			cfg_q.read_recovery_ticks <= i2cee_pkg::READ_RECOVERY_RESET;
		end else if (wr_en) begin
			case (wr_index)
				i2cee_pkg::CFG_DEVICE_SELECT: begin
					cfg_q.device_select <= wr_data[6:0];
				end
				i2cee_pkg::CFG_HALF_PERIOD: begin
					cfg_q.half_period_ticks <= wr_data[7:0];
				end
				i2cee_pkg::CFG_ACK_WAIT: begin
					cfg_q.ack_wait_limit <= wr_data[7:0];
				end
				i2cee_pkg::CFG_WRITE_RECOVERY: begin
					cfg_q.write_recovery_ticks <=
						i2cee_pkg::RECOVERY_COUNT_WIDTH'(wr_data);
				end
				i2cee_pkg::CFG_READ_RECOVERY: begin
					cfg_q.read_recovery_ticks <=
						i2cee_pkg::RECOVERY_COUNT_WIDTH'(wr_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/i2cee_seq.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: bus sequencer
// Steps the bus phase state once per accepted tick and forms that tick's
// line levels and status.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire i2cee_pkg::in_item_t  item,
	input  wire i2cee_pkg::cfg_t      cfg,
	output i2cee_pkg::out_item_t      result
);

	localparam int RW = i2cee_pkg::RECOVERY_COUNT_WIDTH;

	i2cee_pkg::phase_t phase_q, phase_d;
	logic [3:0]    bit_count_q, bit_count_d, bit_inc;
	logic [1:0]    byte_step_q, byte_step_d;
	logic [RW-1:0] tick_q, tick_d, rec_limit;
	logic [RW:0]   tick_sum;
	logic [7:0]    shift_q, shift_d, shifted;
	logic [7:0]    address_q, address_d;
	logic [7:0]    data_q, data_d;
	logic          is_read_q, is_read_d;
	logic [7:0]    last_read_q, last_read_d;
	logic          ack_fail_q, ack_fail_d;
	logic [7:0]    hold;
	logic          scl, rel, done;

	function automatic logic [7:0] load_value(input logic [1:0] bstep, input logic rd,
			input logic [6:0] dev, input logic [7:0] addr, input logic [7:0] wdata);
		logic [7:0] val;
		if (bstep == 2'd0) begin
			val = {dev, 1'b0};
		end else if (bstep == 2'd1) begin
			val = addr;
		end else if (rd) begin
			val = {dev, 1'b1};
		end else begin
			val = wdata;
		end
		return val;
	endfunction

	assign tick_sum = {1'b0, tick_q} + {{RW{1'b0}}, 1'b1};
	assign bit_inc = bit_count_q + 4'd1;
	assign hold = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
	assign rec_limit = is_read_q ? cfg.read_recovery_ticks : cfg.write_recovery_ticks;

	always_comb begin
		phase_d = phase_q;
		bit_count_d = bit_count_q;
		byte_step_d = byte_step_q;
		tick_d = tick_q;
		shift_d = shift_q;
		address_d = address_q;
		data_d = data_q;
		is_read_d = is_read_q;
		last_read_d = last_read_q;
		ack_fail_d = ack_fail_q;
		done = 1'b0;
		scl = 1'b1;
		rel = 1'b1;
		shifted = {shift_q[6:0], 1'b0};

		case (phase_q)
			i2cee_pkg::PH_ST0, i2cee_pkg::PH_WREL, i2cee_pkg::PH_RLO,
			i2cee_pkg::PH_NLO: begin
				scl = 1'b0;
			end
			i2cee_pkg::PH_ST2, i2cee_pkg::PH_P1: begin
				rel = 1'b0;
			end
			i2cee_pkg::PH_ST3, i2cee_pkg::PH_P0: begin
				scl = 1'b0;
				rel = 1'b0;
			end
			i2cee_pkg::PH_WLO: begin
				scl = 1'b0;
				rel = shift_q[7];
			end
			i2cee_pkg::PH_WHI: begin
				rel = shift_q[7];
			end
			default: begin
			end
		endcase

		case (phase_q)
			i2cee_pkg::PH_IDLE: begin
				if (item.command == i2cee_pkg::CMD_READ ||
						item.command == i2cee_pkg::CMD_WRITE) begin
					address_d = item.word_address;
					data_d = item.write_data;
					is_read_d = (item.command == i2cee_pkg::CMD_READ);
					ack_fail_d = 1'b0;
					byte_step_d = 2'd0;
					bit_count_d = 4'd0;
					tick_d = '0;
					phase_d = i2cee_pkg::PH_ST1;
				end
			end
			i2cee_pkg::PH_ACK: begin
				if (!item.sda_in || tick_q >= {{(RW-8){1'b0}}, cfg.ack_wait_limit}) begin
					if (item.sda_in) begin
						ack_fail_d = 1'b1;
					end
					tick_d = '0;
					if (byte_step_q == 2'd0) begin
						byte_step_d = 2'd1;
						shift_d = load_value(2'd1, is_read_q, cfg.device_select,
							address_q, data_q);
						bit_count_d = 4'd0;
						phase_d = i2cee_pkg::PH_WLO;
					end else if (byte_step_q == 2'd1) begin
						byte_step_d = 2'd2;
						if (is_read_q) begin
							phase_d = i2cee_pkg::PH_ST0;
						end else begin
							shift_d = load_value(2'd2, is_read_q, cfg.device_select,
								address_q, data_q);
							bit_count_d = 4'd0;
							phase_d = i2cee_pkg::PH_WLO;
						end
					end else if (is_read_q) begin
						shift_d = 8'd0;
						bit_count_d = 4'd0;
						phase_d = i2cee_pkg::PH_RLO;
					end else begin
						phase_d = i2cee_pkg::PH_P0;
					end
				end else begin
					tick_d = tick_sum[RW-1:0];
				end
			end
			i2cee_pkg::PH_REC: begin
				if (tick_sum >= {1'b0, rec_limit}) begin
					tick_d = '0;
					done = 1'b1;
					phase_d = i2cee_pkg::PH_IDLE;
				end else begin
					tick_d = tick_sum[RW-1:0];
				end
			end
			default: begin
				if (tick_sum >= {{(RW-7){1'b0}}, hold}) begin
					tick_d = '0;
					case (phase_q)
						i2cee_pkg::PH_ST0: phase_d = i2cee_pkg::PH_ST1;
						i2cee_pkg::PH_ST1: phase_d = i2cee_pkg::PH_ST2;
						i2cee_pkg::PH_ST2: phase_d = i2cee_pkg::PH_ST3;
						i2cee_pkg::PH_ST3: begin
							shift_d = load_value(byte_step_q, is_read_q, cfg.device_select,
								address_q, data_q);
							bit_count_d = 4'd0;
							phase_d = i2cee_pkg::PH_WLO;
						end
						i2cee_pkg::PH_WLO: phase_d = i2cee_pkg::PH_WHI;
						i2cee_pkg::PH_WHI: begin
							shift_d = shifted;
							bit_count_d = bit_inc;
							phase_d = bit_inc[3] ? i2cee_pkg::PH_WREL : i2cee_pkg::PH_WLO;
						end
						i2cee_pkg::PH_WREL: phase_d = i2cee_pkg::PH_ACK;
						i2cee_pkg::PH_RLO: phase_d = i2cee_pkg::PH_RHI;
						i2cee_pkg::PH_RHI: begin
							shift_d = {shift_q[6:0], item.sda_in};
							bit_count_d = bit_inc;
							if (bit_inc[3]) begin
								last_read_d = {shift_q[6:0], item.sda_in};
								phase_d = i2cee_pkg::PH_NLO;
							end else begin
								phase_d = i2cee_pkg::PH_RLO;
							end
						end
						i2cee_pkg::PH_NLO: phase_d = i2cee_pkg::PH_NHI;
						i2cee_pkg::PH_NHI: phase_d = i2cee_pkg::PH_P0;
						i2cee_pkg::PH_P0: phase_d = i2cee_pkg::PH_P1;
						i2cee_pkg::PH_P1: phase_d = i2cee_pkg::PH_P2;
						i2cee_pkg::PH_P2: phase_d = i2cee_pkg::PH_REC;
						default: phase_d = i2cee_pkg::PH_IDLE;
					endcase
				end else begin
					tick_d = tick_sum[RW-1:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cee_pkg::PH_IDLE;
			bit_count_q <= 4'd0;
			byte_step_q <= 2'd0;
			tick_q <= '0;
			shift_q <= 8'd0;
			address_q <= 8'd0;
			data_q <= 8'd0;
			is_read_q <= 1'b0;
			last_read_q <= 8'd0;
			ack_fail_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_count_q <= bit_count_d;
			byte_step_q <= byte_step_d;
			tick_q <= tick_d;
			shift_q <= shift_d;
			address_q <= address_d;
			data_q <= data_d;
			is_read_q <= is_read_d;
			last_read_q <= last_read_d;
			ack_fail_q <= ack_fail_d;
		end
	end

	assign result.scl_out = scl;
	assign result.sda_release = rel;
	assign result.busy_res = (phase_d != i2cee_pkg::PH_IDLE);
	assign result.done_res = done;
	assign result.read_byte = last_read_d;
	assign result.ack_missing = ack_fail_d;

endmodule

`default_nettype wire

FILE: hdl/i2c_eeprom_byte_access_master.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: top level
// Single-byte write and random single-byte read of a serial EEPROM over
// SCL and open-drain SDA, one bus timing tick per item.
// ----------------------------------------------------------------------------
// Each accepted item is one bus tick: it carries the sampled SDA level and,
// while the block is idle, an optional read or write command. The block takes
// one item every clock cycle unless a held result is stalled; the sequencer
// updates its phase state in that same cycle and the tick's result, the line
// levels driven during the tick and the status after it, lands in the result
// register and is presented in the next cycle. The next item is taken in the
// cycle a result is presented, as long as that result is consumed, so items
// flow at one per cycle. Bus timing is counted in items, not clock cycles.
`default_nettype none

`include "i2c_eeprom_byte_access_master_defines.svh"

module i2c_eeprom_byte_access_master (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cmd_valid,
	output logic                                     cmd_stall,
	input  wire i2cee_pkg::in_item_t                 cmd_item,
	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output i2cee_pkg::out_item_t                     res_item,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [i2cee_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]    cfg_data
);

	i2cee_pkg::cfg_t      cfg;
	i2cee_pkg::out_item_t result;
	i2cee_pkg::out_item_t res_q;
	logic                 res_valid_q;
	logic                 accept;

	assign cfg_ready = 1'b1;
	assign cmd_stall = res_valid_q & res_stall;
	assign accept = cmd_valid & ~cmd_stall;

	i2cee_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	i2cee_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (cmd_item),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item = res_q;

	`I2CEE_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, res_valid)
	`I2CEE_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, cmd_stall, res_valid)
	`I2CEE_ASSERT_IMPLY(a_done_not_busy, clk, arst_n, res_valid && res_item.done_res, !res_item.busy_res)
	`I2CEE_ASSERT_IMPLY(a_idle_lines_released, clk, arst_n, res_valid && !res_item.busy_res, res_item.scl_out && res_item.sda_release)

endmodule

`default_nettype wire
